// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while out of reset.
`define RMQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define RMQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/rmq_pkg.sv
// ---------------------------------------------------------------------------
// rmq_pkg
// Widths and shared types of the rotation matrix to quaternion block.
// ---------------------------------------------------------------------------
package rmq_pkg;

  localparam int IN_W          = 18;
  localparam int XYZ_W         = 18;
  localparam int W_W           = 17;
  localparam int FRAC_BITS_DEF = 16;
  localparam int N_IN          = 9;
  localparam int IN_TDATA_W    = 168;  // 9 x 18 = 162, padded to bytes
  localparam int OUT_TDATA_W   = 72;   // 3 x 18 + 17 = 71, padded to bytes

  // sign of x, y, z components
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic neg_z;
  } sign_t;

endpackage

// File: hw/rtl/rotation_matrix_to_quaternion.sv
// Pipe: front stages, then R_W root cells (R_W set by FRAC_BITS/DS widths),
// then the output register. One beat accepted per cycle unless the output
// beat stalls. The square root is a chain of R_W cells, one root bit each,
// four lanes side by side. The whole pipe holds while the output beat stalls.
// Reset (rst_n low, synchronous) clears all valid bits; data is not reset.
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix in Q1.FRAC_BITS to unit quaternion by Cayley's method.
// ---------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 (18 bits each), zero pad
  input  logic [rmq_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // quat_x (18), quat_y (18), quat_z (18), quat_w (17), zero pad
  output logic [rmq_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int DS_W = ((rmq_pkg::IN_W > FRAC_BITS + 2) ? rmq_pkg::IN_W : FRAC_BITS + 2) + 2;
  localparam int AB_W = DS_W - 1;
  localparam int S_W  = 2 * AB_W + 2;
  localparam int R_W  = S_W / 2;
  localparam int LAT  = 3 + R_W + 1;
  localparam int Q_W  = ((R_W + 1 > FRAC_BITS + 2) ? R_W + 1 : FRAC_BITS + 2);
  localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_BITS;

  logic en;
  logic [LAT-1:0] vld_r;
  logic signed [rmq_pkg::IN_W-1:0] m [rmq_pkg::N_IN];
  logic [S_W-1:0] s_q [4];
  rmq_pkg::sign_t sg_front;

  logic [S_W-1:0] rad  [4][R_W+1];
  logic [R_W+1:0] rem  [4][R_W+1];
  logic [R_W-1:0] root [4][R_W+1];
  rmq_pkg::sign_t sg_r [R_W];

  logic [Q_W-1:0] mag [4];
  logic [Q_W-1:0] sv  [3];
  logic [rmq_pkg::OUT_TDATA_W-1:0] out_nxt, out_r;

  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;

  always_comb begin
    for (int k = 0; k < rmq_pkg::N_IN; k++) begin
      m[k] = in_tdata[k*rmq_pkg::IN_W +: rmq_pkg::IN_W];
    end
  end

  rmq_front #(.FRAC_BITS(FRAC_BITS), .DS_W(DS_W), .S_W(S_W)) u_front (
    .clk    (clk),
    .en     (en),
    .m_i    (m),
    .s_w_o  (s_q[3]),
    .s_x_o  (s_q[0]),
    .s_y_o  (s_q[1]),
    .s_z_o  (s_q[2]),
    .sign_o (sg_front)
  );

  // lanes: 0 x, 1 y, 2 z, 3 w
  genvar l, c;
  generate
    for (l = 0; l < 4; l++) begin : g_lane
      assign rad[l][0]  = s_q[l];
      assign rem[l][0]  = '0;
      assign root[l][0] = '0;
      for (c = 0; c < R_W; c++) begin : g_cell
        rmq_cell #(.S_W(S_W), .R_W(R_W)) u_cell (
          .clk    (clk),
          .en     (en),
          .rad_i  (rad[l][c]),
          .rem_i  (rem[l][c]),
          .root_i (root[l][c]),
          .rad_o  (rad[l][c+1]),
          .rem_o  (rem[l][c+1]),
          .root_o (root[l][c+1])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      sg_r[0] <= sg_front;
      for (int k = 1; k < R_W; k++) begin
        sg_r[k] <= sg_r[k-1];
      end
      out_r <= out_nxt;
    end
  end

  // round to nearest, saturate at one, then apply sign
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag[k] = (Q_W'(root[k][R_W]) + Q_W'(2)) >> 2;
      if (mag[k] > ONE_Q) begin
        mag[k] = ONE_Q;
      end
    end
    sv[0] = sg_r[R_W-1].neg_x ? -mag[0] : mag[0];
    sv[1] = sg_r[R_W-1].neg_y ? -mag[1] : mag[1];
    sv[2] = sg_r[R_W-1].neg_z ? -mag[2] : mag[2];
    out_nxt = {1'b0, mag[3][rmq_pkg::W_W-1:0], sv[2][rmq_pkg::XYZ_W-1:0],
               sv[1][rmq_pkg::XYZ_W-1:0], sv[0][rmq_pkg::XYZ_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = out_r;

endmodule

// File: hw/rtl/rmq_front.sv
// ---------------------------------------------------------------------------
// rmq_front
// Sums, differences, squares and four-term radicands, three register stages.
// ---------------------------------------------------------------------------
module rmq_front #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
  parameter int DS_W      = 20,
  parameter int S_W       = 40
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [rmq_pkg::IN_W-1:0] m_i [rmq_pkg::N_IN],
  output logic        [S_W-1:0]           s_w_o,
  output logic        [S_W-1:0]           s_x_o,
  output logic        [S_W-1:0]           s_y_o,
  output logic        [S_W-1:0]           s_z_o,
  output rmq_pkg::sign_t                  sign_o
);

  localparam int AB_W = DS_W - 1;
  localparam int SQ_W = 2 * AB_W;
  localparam logic signed [DS_W-1:0] ONE_S = DS_W'(1) << FRAC_BITS;

  logic signed [DS_W-1:0] e [rmq_pkg::N_IN];
  logic signed [DS_W-1:0] t [10];
  logic [AB_W-1:0] ab_nxt [10];
  logic [AB_W-1:0] ab_r   [10];
  logic [SQ_W-1:0] sq_r   [10];
  rmq_pkg::sign_t  sg1_nxt, sg1_r, sg2_r, sg3_r;

  always_comb begin
    for (int k = 0; k < rmq_pkg::N_IN; k++) begin
      e[k] = DS_W'(m_i[k]);
    end
    // 0:p01 1:p02 2:p12 3:n01 4:n02 5:n12 6:dw 7:dx 8:dy 9:dz
    t[0] = e[1] + e[3];
    t[1] = e[2] + e[6];
    t[2] = e[5] + e[7];
    t[3] = e[1] - e[3];
    t[4] = e[2] - e[6];
    t[5] = e[5] - e[7];
    t[6] = e[0] + e[4] + e[8] + ONE_S;
    t[7] = e[0] - e[4] - e[8] + ONE_S;
    t[8] = e[4] - e[0] - e[8] + ONE_S;
    t[9] = e[8] - e[0] - e[4] + ONE_S;
    for (int k = 0; k < 10; k++) begin
      ab_nxt[k] = t[k][DS_W-1] ? AB_W'(-t[k]) : AB_W'(t[k]);
    end
    sg1_nxt.neg_x = (m_i[7] < m_i[5]);
    sg1_nxt.neg_y = (m_i[2] < m_i[6]);
    sg1_nxt.neg_z = (m_i[3] < m_i[1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 10; k++) begin
        ab_r[k] <= ab_nxt[k];
        sq_r[k] <= ab_r[k] * ab_r[k];
      end
      s_w_o  <= S_W'(sq_r[6]) + S_W'(sq_r[5]) + S_W'(sq_r[4]) + S_W'(sq_r[3]);
      s_x_o  <= S_W'(sq_r[5]) + S_W'(sq_r[7]) + S_W'(sq_r[0]) + S_W'(sq_r[1]);
      s_y_o  <= S_W'(sq_r[4]) + S_W'(sq_r[0]) + S_W'(sq_r[8]) + S_W'(sq_r[2]);
      s_z_o  <= S_W'(sq_r[3]) + S_W'(sq_r[1]) + S_W'(sq_r[2]) + S_W'(sq_r[9]);
      sg1_r  <= sg1_nxt;
      sg2_r  <= sg1_r;
      sg3_r  <= sg2_r;
    end
  end

  assign sign_o = sg3_r;

endmodule

// File: hw/rtl/rmq_cell.sv
// ---------------------------------------------------------------------------
// rmq_cell
// One root bit of a restoring square root; registered hand-off to next cell.
// ---------------------------------------------------------------------------
module rmq_cell #(
  parameter int S_W = 40,
  parameter int R_W = 20
) (
  input  logic           clk,
  input  logic           en,
  input  logic [S_W-1:0] rad_i,
  input  logic [R_W+1:0] rem_i,
  input  logic [R_W-1:0] root_i,
  output logic [S_W-1:0] rad_o,
  output logic [R_W+1:0] rem_o,
  output logic [R_W-1:0] root_o
);

  localparam int CW = R_W + 4;

  logic [CW-1:0]  cur, trial;
  logic           ge;
  logic [R_W+1:0] rem_nxt;
  logic [R_W-1:0] root_nxt;

  always_comb begin
    cur      = {rem_i, rad_i[S_W-1 -: 2]};
    trial    = CW'({root_i, 2'b01});
    ge       = (cur >= trial);
    rem_nxt  = ge ? (R_W+2)'(cur - trial) : (R_W+2)'(cur);
    root_nxt = {root_i[R_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_o  <= rad_i << 2;
      rem_o  <= rem_nxt;
      root_o <= root_nxt;
    end
  end

endmodule

// File: hw/rtl/rmq_checker.sv
// ---------------------------------------------------------------------------
// rmq_checker
// Port-level checks of the quaternion block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rmq_checker #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rmq_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam logic [rmq_pkg::W_W-1:0] ONE_W = rmq_pkg::W_W'(1) << FRAC_BITS;
  localparam logic signed [rmq_pkg::XYZ_W-1:0] ONE_X = rmq_pkg::XYZ_W'(1) << FRAC_BITS;
  localparam bit CHK_RANGE = (FRAC_BITS < 16) || (FRAC_BITS == 16);

  logic signed [rmq_pkg::XYZ_W-1:0] qx;
  logic [rmq_pkg::W_W-1:0] qw;
  logic stall, chk, x_ok;
  assign qx    = out_tdata[rmq_pkg::XYZ_W-1:0];
  assign qw    = out_tdata[rmq_pkg::XYZ_W*3 +: rmq_pkg::W_W];
  assign stall = out_tvalid && !out_tready;
  assign chk   = out_tvalid && CHK_RANGE;
  assign x_ok  = (qx <= ONE_X) && (qx >= -ONE_X);

  `RMQ_ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> !out_tvalid, "valid after reset")
  `RMQ_ASSERT(a_hold, clk, rst_n, stall |=> out_tvalid && $stable(out_tdata), "stalled beat changed")
  `RMQ_ASSERT(a_ready, clk, rst_n, stall |-> !in_tready, "accept while pipe full")
  `RMQ_ASSERT(a_w_range, clk, rst_n, chk |-> qw <= ONE_W, "w above one")
  `RMQ_ASSERT(a_x_range, clk, rst_n, chk |-> x_ok, "x out of range")

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(.FRAC_BITS(FRAC_BITS)) u_rmq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
